@@ hw/rtl/des_block_cipher_top_macros.svh @@
// assertion macros for the des block cipher
`ifndef DES_BLOCK_CIPHER_TOP_MACROS_SVH
`define DES_BLOCK_CIPHER_TOP_MACROS_SVH
// assert that a implies b on the same edge
`define DES_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define DES_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/des_pkg.sv @@
// package with des tables and permutation functions
package des_pkg;
    typedef logic [63:0] t_block;
    typedef logic [47:0] t_rkey;
    typedef logic [55:0] t_cd;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam int TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam int TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam int TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam int TAB_PC1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
        61,53,45,37,29,21,13,5,28,20,12,4};
    localparam int TAB_PC2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [15:0] ROT_TWO = 16'b0111111011111100; // bit r: shift of 2
    localparam logic [3:0] TAB_S [8][64] = '{
     '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
       4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
     '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
       0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
     '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
       13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
     '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
       10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
     '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
       4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
     '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
       9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
     '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
       1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
     '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
       7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // initial and final permutations, msb is des bit 1
    function automatic t_block perm_ip(input t_block v);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_IP[i]];
        return r;
    endfunction
    function automatic t_block perm_fp(input t_block v);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_FP[i]];
        return r;
    endfunction
    function automatic t_cd perm_pc1(input t_block v);
        t_cd r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-TAB_PC1[i]];
        return r;
    endfunction
    function automatic t_rkey perm_pc2(input t_cd v);
        t_rkey r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-TAB_PC2[i]];
        return r;
    endfunction
    // feistel function: e, key xor, s-boxes, p
    function automatic logic [31:0] feistel(input logic [31:0] rh, input t_rkey k);
        t_rkey x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0] b;
        for (int i = 0; i < 48; i++) x[47-i] = rh[32-TAB_E[i]];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            b = x[47-6*i -: 6];
            s[31-4*i -: 4] = TAB_S[i][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
        return p;
    endfunction
endpackage

@@ hw/rtl/des_block_cipher_top.sv @@
// top level of the single-block des engine
// Each block is loaded through the initial permutation, then runs ROUNDS
// rounds in the shared round unit and is held in the done state until the
// output is taken; no new block is accepted before then. A key write reloads
// all 16 round keys of the key file (also after reset), during which no block
// is accepted. s_axis_tuser selects 0 encrypt, 1 decrypt.
module des_block_cipher_top
    import des_pkg::*;
#(
    parameter int ROUNDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // block_in
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // block_out
);
    t_rkey      w_rkey;
    logic [3:0] w_idx;
    logic       w_ks_busy, w_rd_busy, w_done;

    des_keysched u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_wr(i_cfg_we), .i_key(i_cfg_wdata),
        .i_rd_idx(w_idx), .o_rkey(w_rkey), .o_busy(w_ks_busy)
    );

    des_round #(.ROUNDS(ROUNDS)) u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_axis_tvalid && s_axis_tready),
        .i_kind(s_axis_tuser), .i_block(s_axis_tdata), .i_rkey(w_rkey),
        .i_taken(m_axis_tready), .o_key_idx(w_idx), .o_busy(w_rd_busy),
        .o_done(w_done), .o_block(m_axis_tdata)
    );

    assign s_axis_tready = !w_rd_busy && !w_ks_busy;
    assign m_axis_tvalid = w_done;
endmodule

@@ hw/rtl/des_keysched.sv @@
// key schedule: one round key per cycle into a register file
module des_keysched
    import des_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_key_wr,
    input  t_block      i_key,
    input  logic [3:0]  i_rd_idx,
    output t_rkey       o_rkey,
    output logic        o_busy
);
    t_rkey      r_keys [16];
    t_rkey      r_rkey;
    t_cd        r_cd;
    logic [3:0] r_cnt;
    logic       r_busy;
    logic [27:0] w_c, w_d;
    logic        w_two;

    // rotate both halves by the schedule amount of this round
    always_comb begin
        w_two = ROT_TWO[r_cnt];
        w_c = w_two ? {r_cd[53:28], r_cd[55:54]} : {r_cd[54:28], r_cd[55]};
        w_d = w_two ? {r_cd[25:0], r_cd[27:26]} : {r_cd[26:0], r_cd[27]};
    end

    // sequencer, a key write or reset restarts the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_cd   <= '0;
        end else if (i_key_wr) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_cd   <= perm_pc1(i_key);
        end else if (r_busy) begin
            r_cd  <= {w_c, w_d};
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) r_busy <= 1'b0;
        end
    end

    // key file write during the sweep, registered read for the round engine
    always_ff @(posedge i_clk) begin
        if (r_busy && !i_key_wr) r_keys[r_cnt] <= perm_pc2({w_c, w_d});
        r_rkey <= r_keys[i_rd_idx];
    end

    assign o_rkey = r_rkey;
    assign o_busy = r_busy;
endmodule

@@ hw/rtl/des_round.sv @@
// round engine: one shared feistel round per cycle
module des_round
    import des_pkg::*;
#(
    parameter int ROUNDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_kind,
    input  t_block      i_block,
    input  t_rkey       i_rkey,
    input  logic        i_taken,
    output logic [3:0]  o_key_idx,
    output logic        o_busy,
    output logic        o_done,
    output t_block      o_block
);
    localparam logic [3:0] LAST = 4'(ROUNDS - 1);
    logic [1:0]  r_state;
    logic [3:0]  r_n;
    logic        r_dec;
    logic [31:0] r_l, r_r;
    t_block      r_out;
    logic [3:0]  w_next_n;
    logic        w_next_dec;

    // key index of the next round, the key file answers in the cycle after
    always_comb begin
        w_next_n   = (r_state == ST_IDLE) ? 4'd0 : (r_n + 4'd1);
        w_next_dec = (r_state == ST_IDLE) ? i_kind : r_dec;
        o_key_idx  = w_next_dec ? (LAST - w_next_n) : w_next_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_dec   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_RUN;
                        r_n <= '0;
                        r_dec <= i_kind;
                    end
                end
                ST_RUN: begin
                    r_n <= r_n + 4'd1;
                    if (r_n == LAST) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_taken) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // data path: ip at load, one round per cycle, swap and fp at the end
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            {r_l, r_r} <= perm_ip(i_block);
        end else if (r_state == ST_RUN) begin
            r_l <= r_r;
            r_r <= r_l ^ feistel(r_r, i_rkey);
            if (r_n == LAST) r_out <= perm_fp({r_l ^ feistel(r_r, i_rkey), r_r});
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_done  = (r_state == ST_DONE);
    assign o_block = r_out;
endmodule

@@ hw/rtl/des_chk.sv @@
// port checker for the des block cipher top level
`include "des_block_cipher_top_macros.svh"
module des_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    `DES_ASSERT_IMP(a_no_acc_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `DES_ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)
    `DES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind des_block_cipher_top des_chk u_chk (.*);

@@ tb/sv/testbench.sv @@
// testbench for the des block cipher: directed and random blocks under a self-checking scoreboard
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import des_pkg::*;

    localparam int ROUNDS = 16;
    localparam int KEY_RELOAD_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    // des predictor with its own key schedule
    class des_scoreboard;
        logic [47:0] subkeys [16];
        logic [63:0] pending_blocks [$];
        int errors;

        function new();
            errors = 0;
            load_key(64'd0);
        endfunction

        function automatic void load_key(input logic [63:0] key);
            logic [55:0] cd;
            logic [27:0] c;
            logic [27:0] d;
            logic [55:0] joined;
            int sh;
            for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
            c = cd[55:28];
            d = cd[27:0];
            for (int r = 0; r < 16; r++) begin
                sh = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
                c = (c << sh) | (c >> (28 - sh));
                d = (d << sh) | (d >> (28 - sh));
                joined = {c, d};
                for (int i = 0; i < 48; i++) subkeys[r][47-i] = joined[56-TAB_PC2[i]];
            end
        endfunction

        function automatic logic [31:0] round_fn(input logic [31:0] rh, input logic [47:0] k);
            logic [47:0] x;
            logic [5:0] b;
            logic [31:0] s;
            logic [31:0] p;
            for (int i = 0; i < 48; i++) x[47-i] = rh[32-TAB_E[i]];
            x = x ^ k;
            for (int i = 0; i < 8; i++) begin
                b = x[47-6*i -: 6];
                s[31-4*i -: 4] = TAB_S[i][{b[5], b[0]} * 16 + b[4:1]];
            end
            for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
            return p;
        endfunction

        function automatic logic [63:0] cipher_block(input logic kind, input logic [63:0] blk);
            logic [63:0] t;
            logic [63:0] o;
            logic [31:0] l;
            logic [31:0] r;
            logic [31:0] nr;
            int ki;
            for (int i = 0; i < 64; i++) t[63-i] = blk[64-TAB_IP[i]];
            l = t[63:32];
            r = t[31:0];
            for (int n = 0; n < ROUNDS; n++) begin
                ki = (kind == KIND_DECRYPT) ? (ROUNDS - 1 - n) : n;
                nr = l ^ round_fn(r, subkeys[ki & 15]);
                l = r;
                r = nr;
            end
            t = {r, l};
            for (int i = 0; i < 64; i++) o[63-i] = t[64-TAB_FP[i]];
            return o;
        endfunction

        function automatic void note_block(input logic kind, input logic [63:0] blk);
            pending_blocks.push_back(cipher_block(kind, blk));
        endfunction

        function automatic void check_block(input logic [63:0] got);
            logic [63:0] want;
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected block_out %h", $realtime, got);
                errors++;
            end else begin
                want = pending_blocks.pop_front();
                if (want !== got) begin
                    $display("%0t: block_out mismatch expected %h actual %h",
                             $realtime, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [63:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // block_in
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // block_out

    des_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    des_block_cipher_top #(.ROUNDS(ROUNDS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_ENCRYPT;
        m_axis_tready = 1'b0;
    end

    // receiver: random stalls, result check on each transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_block(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one block transaction with a random gap before it, valid dropped after it
    task automatic send_block(input logic kind, input logic [63:0] blk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= blk;
        s_axis_tuser <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_block(kind, blk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending_blocks.size() != 0) @(posedge i_clk);
        repeat (ROUNDS + 4) @(posedge i_clk);
    endtask

    // key write while idle
    task automatic write_key(input logic [63:0] key);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= key;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.load_key(key);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] shaped_block();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3: return ~(64'd1 << $urandom_range(63));
            default: return rand64();
        endcase
    endfunction

    initial begin
        logic [63:0] k;
        logic [63:0] p;
        sb = new();
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset key, known vector, extremes, weak keys
        send_block(KIND_ENCRYPT, 64'd0);
        send_block(KIND_DECRYPT, 64'd0);
        send_block(KIND_ENCRYPT, '1);
        send_block(KIND_DECRYPT, '1);
        write_key(64'h1334_5779_9BBC_DFF1);
        send_block(KIND_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        send_block(KIND_DECRYPT, 64'h85E8_1354_0F0A_B405);
        send_block(KIND_ENCRYPT, 64'h8000_0000_0000_0000);
        send_block(KIND_ENCRYPT, 64'h0000_0000_0000_0001);
        write_key('1);
        send_block(KIND_ENCRYPT, 64'd0);
        send_block(KIND_DECRYPT, '1);
        // parity bits only: same schedule as the all-zero key
        write_key(64'h0101_0101_0101_0101);
        send_block(KIND_ENCRYPT, 64'hAAAA_5555_AAAA_5555);
        send_block(KIND_DECRYPT, 64'h5555_AAAA_5555_AAAA);
        write_key(64'hFEFE_FEFE_FEFE_FEFE);
        send_block(KIND_ENCRYPT, 64'h0123_4567_89AB_CDEF);

        // random phases with changing idle mix and keys
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 30 : 0;
            for (int kset = 0; kset < 4; kset++) begin
                write_key((kset == 0 && phase == 2) ? '1 : rand64());
                for (int n = 0; n < 29; n++) begin
                    // encrypt then decrypt of the same block in most pairs
                    p = shaped_block();
                    k = sb.cipher_block(KIND_ENCRYPT, p);
                    send_block(KIND_ENCRYPT, p);
                    if ($urandom_range(3) != 0) send_block(KIND_DECRYPT, k);
                    else send_block(1'($urandom_range(1)), shaped_block());
                    if (n == 10) while (sb.pending_blocks.size() != 0) @(posedge i_clk);
                end
            end
        end
        write_key(64'd0);
        send_block(KIND_ENCRYPT, rand64());

        drain();
        if (sb.errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/des_pkg.sv
hw/rtl/des_keysched.sv
hw/rtl/des_round.sv
hw/rtl/des_block_cipher_top.sv
hw/rtl/des_chk.sv
tb/sv/testbench.sv
